@@ rtl/core/ssq_pkg.sv @@
// Sorted-set priority queue: shared types, codes and helpers.
// No dependencies; imported by ssq_cell, sorted_set_priority_queue and the testbench.
`default_nettype none

package ssq_pkg;

  localparam int VALUE_W   = 32;
  localparam int CFG_W     = 6;
  localparam int COUNT_OUT_W = 6;
  localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_SEARCH  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  // per-cycle orders broadcast to every cell
  typedef struct packed {
    logic capture;    // latch compare flags against operand
    logic insert;     // open a slot at the insertion point
    logic remove;     // close the slot at the match point
    logic from_head;  // remove shifts every cell (extract)
  } cell_ctl_t;

  function automatic logic key_less(input logic [VALUE_W-1:0] a,
                                    input logic [VALUE_W-1:0] b);
    key_less = $signed(a) < $signed(b);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/sorted_set_priority_queue.sv @@
// Sorted-set priority queue top level: control sequencer, count and result register.
// Depends on ssq_pkg and ssq_cell.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: command, value
//  m_*      out  m_tvalid/m_tready  m_tdata: status, result_value, entry_count
//  cfg_*    in   cfg_wen            cfg_wdata: capacity
//
// Each item passes through accept (S_IDLE), a parallel compare in every cell (S_CMP),
// then S_APPLY, where the chain shifts and the result is loaded. A stalled result holds the sequencer in
// its last step; the next item is accepted once that result is loaded.
// Reset (rst, synchronous) empties the set and sets capacity to 32; no clearing pass.
`default_nettype none

module sorted_set_priority_queue import ssq_pkg::*; #(
  parameter int MAX_ENTRIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [1:0] command, [33:2] value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [2:0] status, [34:3] result_value, [40:35] entry_count
  input  wire logic        cfg_wen,
  input  wire logic [5:0]  cfg_wdata
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [WW-1:0] MAX_W = WW'(MAX_ENTRIES);

  state_t state, state_next;
  logic [CFG_W-1:0] capacity;
  logic [CW-1:0] count, count_next;
  cmd_t cmd;
  logic [VALUE_W-1:0] operand;

  logic out_free;
  status_t status_next;
  logic [VALUE_W-1:0] res_next;
  cell_ctl_t ctl;

  logic [VALUE_W-1:0] entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] lt_vec, eq_vec, occ;
  logic found;
  logic [WW-1:0] count_w, cap_w;

  status_t out_status;
  logic [VALUE_W-1:0] out_value;
  logic [COUNT_OUT_W-1:0] out_count;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      assign occ[gi] = count > CW'(gi);
      ssq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .operand    (operand),
        .occ        (occ[gi]),
        .prev_lt    ((gi == 0) ? 1'b1 : lt_vec[(gi == 0) ? 0 : gi - 1]),
        .prev_entry ((gi == 0) ? operand : entry[(gi == 0) ? 0 : gi - 1]),
        .next_entry ((gi == MAX_ENTRIES - 1) ? entry[gi]
                                             : entry[(gi == MAX_ENTRIES - 1) ? gi : gi + 1]),
        .entry      (entry[gi]),
        .lt         (lt_vec[gi]),
        .eq         (eq_vec[gi])
      );
    end
  endgenerate

  assign found    = |eq_vec;
  assign count_w  = WW'(count);
  assign cap_w    = (WW'(capacity) > MAX_W) ? MAX_W : WW'(capacity);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    count_next  = count;
    status_next = ST_OK;
    res_next    = '0;
    ctl         = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_CMP;
      end
      S_CMP: begin
        ctl.capture = 1'b1;
        state_next  = S_APPLY;
      end
      S_APPLY: begin
        case (cmd)
          CMD_INSERT: begin
            if (count_w >= cap_w) status_next = ST_FULL;
            else if (found) status_next = ST_DUP;
          end
          CMD_EXTRACT: begin
            if (count == '0) status_next = ST_EMPTY;
            else res_next = entry[0];
          end
          CMD_DELETE, CMD_SEARCH: begin
            if (!found) status_next = ST_NOTFOUND;
          end
          default: status_next = ST_OK;
        endcase
        if (out_free) begin
          state_next = S_IDLE;
          if (status_next == ST_OK) begin
            case (cmd)
              CMD_INSERT: begin
                ctl.insert = 1'b1;
                count_next = count + CW'(1);
              end
              CMD_EXTRACT: begin
                ctl.remove    = 1'b1;
                ctl.from_head = 1'b1;
                count_next    = count - CW'(1);
              end
              CMD_DELETE: begin
                ctl.remove = 1'b1;
                count_next = count - CW'(1);
              end
              default: count_next = count;
            endcase
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      capacity <= CAP_RESET;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_wen) capacity <= cfg_wdata;
      if (state == S_APPLY && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd     <= cmd_t'(s_tdata[1:0]);
      operand <= s_tdata[33:2];
    end
    if (state == S_APPLY && out_free) begin
      out_status <= status_next;
      out_value  <= res_next;
      out_count  <= COUNT_OUT_W'(WW'(count_next));
    end
  end

  assign m_tdata = {7'd0, out_count, out_value, out_status};

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    WW'(count) <= MAX_W)
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && out_free && cmd == CMD_INSERT && status_next == ST_OK)
    |=> count == $past(count) + CW'(1))
    else $error("insert did not grow count");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == ST_EMPTY) |-> (out_count == '0 && out_value == '0))
    else $error("empty result with nonzero fields");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && occ[1]) |-> key_less(entry[0], entry[1]))
    else $error("head entries out of order");

endmodule

`default_nettype wire

@@ rtl/core/ssq_cell.sv @@
// One storage cell of the sorted chain: holds an entry and its compare flags.
// Depends on ssq_pkg.
`default_nettype none

module ssq_cell import ssq_pkg::*; (
  input  wire logic               clk,
  input  wire cell_ctl_t          ctl,
  input  wire logic [VALUE_W-1:0] operand,
  input  wire logic               occ,
  input  wire logic               prev_lt,
  input  wire logic [VALUE_W-1:0] prev_entry,
  input  wire logic [VALUE_W-1:0] next_entry,
  output logic [VALUE_W-1:0]      entry,
  output logic                    lt,
  output logic                    eq
);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      lt <= occ && key_less(entry, operand);
      eq <= occ && (entry == operand);
    end
    if (ctl.insert && !lt) begin
      entry <= prev_lt ? operand : prev_entry;
    end else if (ctl.remove && (ctl.from_head || !lt)) begin
      entry <= next_entry;
    end
  end

endmodule

`default_nettype wire

@@ tb/sorted_set_priority_queue_tb.sv @@
// Self-checking testbench for sorted_set_priority_queue: a directed opening, then random
// command streams under several capacities, checked against an in-bench sorted-set predictor.
// Depends on ssq_pkg and the sorted_set_priority_queue RTL.
`default_nettype none

module sorted_set_priority_queue_tb;
  import ssq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    status_t     status;
    logic [31:0] value;
    logic [5:0]  count;
  } op_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [1:0] command, [33:2] value
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [2:0] status, [34:3] result_value, [40:35] entry_count
  logic        cfg_wen;
  logic [5:0]  cfg_wdata;

  sorted_set_priority_queue #(.MAX_ENTRIES(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [31:0] set_vals [DEPTH];
  int          held;
  logic [5:0]  cap_reg;

  logic [39:0] op_queue [$];
  op_result_t  want_results [$];
  int          err_count;
  int          cycles;
  bit          took;

  int          burst_left;
  int          gap_left;
  logic [15:0] ready_pat;
  int          pat_left;

  logic [31:0] val_pool [48];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held; i++) set_vals[i] = set_vals[i + 1];
    held--;
  endfunction

  function automatic op_result_t sorted_set_apply(cmd_t cmd, logic [31:0] v);
    op_result_t r;
    int pos;
    int lim;
    bit hit;
    r.status = ST_OK;
    r.value = '0;
    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    pos = 0;
    for (int i = 0; i < held; i++) if ($signed(set_vals[i]) < $signed(v)) pos++;
    hit = (pos < held) && (set_vals[pos] == v);
    case (cmd)
      CMD_INSERT: begin
        if (held >= lim) r.status = ST_FULL;
        else if (hit) r.status = ST_DUP;
        else begin
          for (int i = held; i > pos; i--) set_vals[i] = set_vals[i - 1];
          set_vals[pos] = v;
          held++;
        end
      end
      CMD_EXTRACT: begin
        if (held == 0) r.status = ST_EMPTY;
        else begin
          r.value = set_vals[0];
          drop_entry(0);
        end
      end
      CMD_DELETE: begin
        if (hit) drop_entry(pos);
        else r.status = ST_NOTFOUND;
      end
      default: begin
        if (!hit) r.status = ST_NOTFOUND;
      end
    endcase
    r.count = held[5:0];
    return r;
  endfunction

  function automatic logic [39:0] pack_item(cmd_t c, logic [31:0] v);
    return {6'b0, v, c};
  endfunction

  // input accept, prediction and result check
  always @(posedge clk) begin
    op_result_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      took = 1'b0;
      if (!rst) begin
        if (s_tvalid && s_tready) begin
          took = 1'b1;
          void'(op_queue.pop_front());
          want_results.push_back(sorted_set_apply(cmd_t'(s_tdata[1:0]), s_tdata[33:2]));
        end
        if (m_tvalid && m_tready) begin
          if (want_results.size() == 0) begin
            $display("%0t: unexpected item %h", $time, m_tdata);
            err_count++;
          end else begin
            e = want_results.pop_front();
            if (m_tdata[2:0] !== e.status) begin
              $display("%0t: status exp %0d got %0d", $time, e.status, m_tdata[2:0]);
              err_count++;
            end
            if (m_tdata[34:3] !== e.value) begin
              $display("%0t: result_value exp %h got %h", $time, e.value, m_tdata[34:3]);
              err_count++;
            end
            if (m_tdata[40:35] !== e.count) begin
              $display("%0t: entry_count exp %0d got %0d", $time, e.count, m_tdata[40:35]);
              err_count++;
            end
          end
        end
      end
    end
  end

  // sender: bursts with gaps, holds an item until taken
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || took)) begin
      if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left--;
      end else if (op_queue.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata  <= op_queue[0];
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: random stall patterns from a 16-bit ready mask, sometimes none
  always @(negedge clk) begin
    if (!rst) begin
      if (pat_left == 0) begin
        ready_pat = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
        pat_left = 16;
      end
      m_tready <= ready_pat[pat_left - 1];
      pat_left--;
    end
  end

  task automatic set_capacity(logic [5:0] c);
    while (op_queue.size() != 0 || want_results.size() != 0 || s_tvalid) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wdata <= c;
    cfg_wen   <= 1'b1;
    cap_reg = c;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic add_random(int n, int ins_pct, int pool_n);
    int r;
    cmd_t c;
    logic [31:0] v;
    for (int i = 0; i < 48; i++) begin
      if (i % 2 == 0) val_pool[i] = $urandom;
      else val_pool[i] = 32'($signed($urandom_range(0, 40)) - 20);
    end
    val_pool[1] = 32'h8000_0000;
    val_pool[3] = 32'h7FFF_FFFF;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < ins_pct) c = CMD_INSERT;
      else if (r < ins_pct + (100 - ins_pct) / 3) c = CMD_EXTRACT;
      else if (r < ins_pct + 2 * (100 - ins_pct) / 3) c = CMD_DELETE;
      else c = CMD_SEARCH;
      v = ($urandom_range(99) < 85) ? val_pool[$urandom_range(pool_n - 1)] : $urandom;
      op_queue.push_back(pack_item(c, v));
    end
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    cfg_wen    = 1'b0;
    cfg_wdata  = '0;
    held       = 0;
    cap_reg    = CAP_RESET;
    err_count  = 0;
    cycles     = 0;
    took       = 1'b0;
    burst_left = 0;
    gap_left   = 0;
    pat_left   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty set, extremes, duplicates, absent values
    op_queue.push_back(pack_item(CMD_EXTRACT, 32'h1234_5678));
    op_queue.push_back(pack_item(CMD_DELETE, 32'd5));
    op_queue.push_back(pack_item(CMD_SEARCH, 32'd5));
    op_queue.push_back(pack_item(CMD_INSERT, 32'h7FFF_FFFF));
    op_queue.push_back(pack_item(CMD_INSERT, 32'h8000_0000));
    op_queue.push_back(pack_item(CMD_INSERT, 32'h0));
    op_queue.push_back(pack_item(CMD_INSERT, 32'h0));
    op_queue.push_back(pack_item(CMD_INSERT, 32'hFFFF_FFFF));
    op_queue.push_back(pack_item(CMD_INSERT, 32'h1));
    op_queue.push_back(pack_item(CMD_SEARCH, 32'h8000_0000));
    op_queue.push_back(pack_item(CMD_SEARCH, 32'h2));
    op_queue.push_back(pack_item(CMD_DELETE, 32'h2));
    op_queue.push_back(pack_item(CMD_DELETE, 32'h7FFF_FFFF));
    op_queue.push_back(pack_item(CMD_DELETE, 32'h0));
    op_queue.push_back(pack_item(CMD_EXTRACT, 32'hFFFF_FFFF));
    op_queue.push_back(pack_item(CMD_EXTRACT, 32'h0));
    op_queue.push_back(pack_item(CMD_EXTRACT, 32'h0));
    op_queue.push_back(pack_item(CMD_EXTRACT, 32'h0));
    op_queue.push_back(pack_item(CMD_INSERT, 32'h5555_5555));
    op_queue.push_back(pack_item(CMD_INSERT, 32'hAAAA_AAAA));
    op_queue.push_back(pack_item(CMD_SEARCH, 32'hAAAA_AAAA));
    op_queue.push_back(pack_item(CMD_SEARCH, 32'h5555_5555));

    // 63 saturates to the depth; later phases lower capacity below the count
    set_capacity(6'd63);
    add_random(60, 70, 40);
    set_capacity(6'd2);
    add_random(30, 40, 40);
    set_capacity(6'd0);
    add_random(25, 50, 16);
    set_capacity(6'd1);
    add_random(30, 45, 6);
    set_capacity(6'd7);
    add_random(40, 50, 12);
    set_capacity(6'd32);
    add_random(70, 65, 48);
    set_capacity(6'd16);
    add_random(40, 35, 24);
    set_capacity(6'd33);
    add_random(40, 50, 40);
    set_capacity(6'd5);
    add_random(40, 25, 10);

    while (op_queue.size() != 0 || want_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (want_results.size() != 0) err_count++;
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/core/ssq_pkg.sv
rtl/core/ssq_cell.sv
rtl/core/sorted_set_priority_queue.sv
tb/sorted_set_priority_queue_tb.sv
